// ===== rtl/core/pwn_pkg.sv =====
package pwn_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF   = 16;

  localparam int KIND_W  = 2;
  localparam int WIND_W  = 9;
  localparam int TOTAL_W = 9;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic clear;
    logic append;
    logic q_start;
    logic rd_issue;
    logic v0_load;
    logic stage;
    logic load_out;
  } pwn_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic n_zero;
    logic last_edge;
  } pwn_status_t;

endpackage

// ===== rtl/core/pwn_ctrl.sv =====
module pwn_ctrl
  import pwn_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] kind_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pwn_status_t       status_i,
  output pwn_cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FIRST,
    ST_EDGE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_CLEAR:  cmd_o.clear = 1'b1;
            KIND_APPEND: cmd_o.append = 1'b1;
            KIND_QUERY: begin
              cmd_o.q_start = 1'b1;
              state_d       = ST_START;
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        if (status_i.n_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.v0_load  = 1'b1;
        state_d        = ST_EDGE;
      end
      ST_EDGE: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.v0_load  = 1'b1;
        cmd_o.stage    = 1'b1;
        if (status_i.last_edge) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last edge's products settle into the accumulator here.
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result word loaded over a pending one");

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result valid rose outside the done state");

  a_stage_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EDGE) |-> ($past(state_q == ST_FIRST) || $past(state_q == ST_EDGE)))
    else $error("edge stage entered without the first vertex loaded");

endmodule

// ===== rtl/core/pwn_datapath.sv =====
module pwn_datapath
  import pwn_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  pwn_cmd_t                     cmd_i,
  output pwn_status_t                  status_o,
  output logic signed [WIND_W-1:0]     winding_o,
  output logic                         overflowed_o,
  output logic [TOTAL_W-1:0]           vertex_total_o
);

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // Vertex store.
  logic signed [COORD_BITS-1:0] x_mem [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] y_mem [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          full;

  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [IW-1:0]                addr_q, addr_d;
  logic [CW-1:0]                addr_inc;
  logic [CW-1:0]                edge_cnt_q, edge_cnt_d;
  logic [CW-1:0]                edge_inc;

  logic signed [COORD_BITS-1:0] v0_x_q, v0_y_q;

  logic signed [DW-1:0] dx10, dyp0, dxp0, dy10;
  logic signed [PW-1:0] prod1_q, prod2_q, prod1_d, prod2_d;
  logic                 up_q, dn_q, up_d, dn_d;
  logic                 pv_q;

  logic [WIND_W-1:0] wn_q, wn_d;

  logic signed [WIND_W-1:0] wind_out_q;
  logic                     ovf_out_q;
  logic [TOTAL_W-1:0]       total_out_q;

  assign full     = (count_q == CW'(MAX_VERTICES));
  assign addr_inc = CW'(addr_q) + CW'(1);
  assign edge_inc = edge_cnt_q + CW'(1);

  assign status_o.n_zero    = (count_q == '0);
  assign status_o.last_edge = (edge_inc == count_q);

  // Store write and registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      x_mem[count_q[IW-1:0]] <= x_i;
      y_mem[count_q[IW-1:0]] <= y_i;
    end
    if (cmd_i.rd_issue) begin
      rd_x_q <= x_mem[addr_q];
      rd_y_q <= y_mem[addr_q];
    end
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.clear) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.append) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  // Reads walk 0, 1, ..., n-1 and wrap to 0 for the closing edge.
  always_comb begin
    addr_d     = addr_q;
    edge_cnt_d = edge_cnt_q;
    if (cmd_i.q_start) begin
      addr_d     = '0;
      edge_cnt_d = '0;
    end else begin
      if (cmd_i.rd_issue) begin
        addr_d = (addr_inc == count_q) ? '0 : IW'(addr_inc);
      end
      if (cmd_i.stage) begin
        edge_cnt_d = edge_inc;
      end
    end
  end

  // Edge stage: v0 holds v[i], the read register holds v[i+1].
  always_comb begin
    dx10    = DW'(rd_x_q) - DW'(v0_x_q);
    dyp0    = DW'(py_q) - DW'(v0_y_q);
    dxp0    = DW'(px_q) - DW'(v0_x_q);
    dy10    = DW'(rd_y_q) - DW'(v0_y_q);
    prod1_d = dx10 * dyp0;
    prod2_d = dxp0 * dy10;
    up_d    = (v0_y_q <= py_q) && (rd_y_q > py_q);
    dn_d    = (v0_y_q > py_q) && (rd_y_q <= py_q);
  end

  always_comb begin
    wn_d = wn_q;
    if (cmd_i.q_start) begin
      wn_d = '0;
    end else if (pv_q && up_q && (prod1_q > prod2_q)) begin
      wn_d = wn_q + WIND_W'(1);
    end else if (pv_q && dn_q && (prod1_q < prod2_q)) begin
      wn_d = wn_q - WIND_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      px_q <= x_i;
      py_q <= y_i;
    end
    if (cmd_i.v0_load) begin
      v0_x_q <= rd_x_q;
      v0_y_q <= rd_y_q;
    end
    if (cmd_i.stage) begin
      prod1_q <= prod1_d;
      prod2_q <= prod2_d;
      up_q    <= up_d;
      dn_q    <= dn_d;
    end
    if (cmd_i.load_out) begin
      wind_out_q  <= wn_q;
      ovf_out_q   <= ovf_q;
      total_out_q <= TOTAL_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      ovf_q      <= 1'b0;
      addr_q     <= '0;
      edge_cnt_q <= '0;
      pv_q       <= 1'b0;
      wn_q       <= '0;
    end else begin
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      addr_q     <= addr_d;
      edge_cnt_q <= edge_cnt_d;
      pv_q       <= cmd_i.stage;
      wn_q       <= wn_d;
    end
  end

  assign winding_o      = wind_out_q;
  assign overflowed_o   = ovf_out_q;
  assign vertex_total_o = total_out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_issue && count_q != '0) |-> (CW'(addr_q) < count_q))
    else $error("store read beyond the written vertices");

  a_ovf_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(full))
    else $error("overflow flag set while the store had room");

endmodule

// ===== rtl/core/polygon_winding_number.sv =====
// Polygon store with winding-number point-in-polygon queries. Words with kind 0
// clear the polygon, kind 1 append a vertex (dropped, with the sticky overflow
// flag set, once MAX_VERTICES are stored), kind 2 query a point and kind 3 are
// ignored; only a query yields a result word. Coordinates are signed fixed point
// and the edge side tests are exact. A query walks the stored vertices in order
// (none when the store is empty) through the single read port of the vertex
// store, which delivers one vertex per cycle to the edge stage. The block accepts
// new words while a finished result waits on the output.
module polygon_winding_number
  import pwn_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [KIND_W-1:0]            kind_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [WIND_W-1:0]     winding_o,
  output logic                         overflowed_o,
  output logic [TOTAL_W-1:0]           vertex_total_o
);

  pwn_cmd_t    cmd;
  pwn_status_t status;

  pwn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pwn_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .x_i            (x_i),
    .y_i            (y_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .winding_o      (winding_o),
    .overflowed_o   (overflowed_o),
    .vertex_total_o (vertex_total_o)
  );

endmodule
